// ===== rtl/flrc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the link response checker
// no dependencies; used by flrc_store, flrc_frame and fpga_link_response_checker
package flrc_pkg;

	localparam int STORE_DEPTH = 32;
	localparam int MAC_W = 48;
	localparam int POS_W = 11;

	// item kinds on the input channel (code 3 is ignored)
	localparam logic [1:0] KIND_REQ  = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_OWN_MAC  = 1'b0;
	localparam logic [0:0] REG_PEER_MAC = 1'b1;

	// frame layout
	localparam logic [POS_W-1:0] POS_SRC_START  = 11'd6;
	localparam logic [POS_W-1:0] POS_HDR_START  = 11'd16;
	localparam logic [POS_W-1:0] POS_DATA_START = 11'd20;
	localparam logic [POS_W-1:0] POS_ECHO_END   = 11'd24;
	localparam logic [POS_W-1:0] POS_MAX        = 11'd2047;

	// set response codes
	localparam logic [7:0] SET_FUNC = 8'h80;
	localparam logic [7:0] SET_SUB  = 8'h00;

	// response table: get entry and set entry
	localparam logic [15:0] RESP_GET_LEN  = 16'h000B;
	localparam logic [7:0]  RESP_GET_FUNC = 8'h00;
	localparam logic [7:0]  RESP_GET_SUB  = 8'h80;
	localparam logic [15:0] RESP_SET_LEN  = 16'h0006;
	localparam logic [7:0]  RESP_SET_FUNC = 8'h80;
	localparam logic [7:0]  RESP_SET_SUB  = 8'h00;

	typedef enum logic [2:0] {
		VERDICT_OK      = 3'd0,
		VERDICT_SHORT   = 3'd1,
		VERDICT_ADDRESS = 3'd2,
		VERDICT_FUNC    = 3'd3,
		VERDICT_LENGTH  = 3'd4,
		VERDICT_ECHO    = 3'd5
	} verdict_t;

	// pending request as recorded
	typedef struct packed {
		logic [7:0]  func;
		logic [7:0]  sub;
		logic        get;
		logic [15:0] seq;
	} pend_t;

	// frame judgement handed to the top level
	typedef struct packed {
		logic       fire;
		verdict_t   verdict;
		logic       accept;
		logic [5:0] count;
	} frame_res_t;

endpackage

// ===== rtl/flrc_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces of the link response checker
// depends on nothing; used by fpga_link_response_checker
interface flrc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] req_func;
	logic [7:0] req_subfunc;
	logic       req_is_get;
	logic [7:0] frame_byte;
	logic       frame_last;
	logic [4:0] read_index;

	modport source (output valid, kind, req_func, req_subfunc, req_is_get, frame_byte,
		frame_last, read_index, input ready);
	modport sink (input valid, kind, req_func, req_subfunc, req_is_get, frame_byte,
		frame_last, read_index, output ready);
endinterface

interface flrc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic        done_flag;
	logic [15:0] issued_sequence;
	logic [5:0]  data_count;
	logic [7:0]  data_byte;

	modport source (output valid, verdict, done_flag, issued_sequence, data_count, data_byte,
		input ready);
	modport sink (input valid, verdict, done_flag, issued_sequence, data_count, data_byte,
		output ready);
endinterface

// ===== rtl/flrc_store.sv =====
`timescale 1ns / 1ps
// double-buffered capture store: one write port, one registered read port
// depends on flrc_pkg for the default depth
module flrc_store #(
	parameter int STORE_DEPTH = flrc_pkg::STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic                           wr_bank,
	input  logic [$clog2(STORE_DEPTH)-1:0] wr_off,
	input  logic [7:0]                     wr_data,
	input  logic                           rd_en,
	input  logic                           rd_bank,
	input  logic [$clog2(STORE_DEPTH)-1:0] rd_off,
	output logic [7:0]                     rd_data
);
	localparam int ADDR_W = $clog2(2 * STORE_DEPTH);
	localparam int DEPTH  = 2 * STORE_DEPTH;

	logic [7:0]        mem [DEPTH];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	assign wr_addr = wr_bank ? ADDR_W'(STORE_DEPTH) + ADDR_W'(wr_off) : ADDR_W'(wr_off);
	assign rd_addr = rd_bank ? ADDR_W'(STORE_DEPTH) + ADDR_W'(rd_off) : ADDR_W'(rd_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ===== rtl/flrc_frame.sv =====
`timescale 1ns / 1ps
// frame byte tracker: address checks, header capture, data writes and judgement
// depends on flrc_pkg
module flrc_frame #(
	parameter int STORE_DEPTH = flrc_pkg::STORE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [7:0]                        byte_in,
	input  logic                              last,
	input  logic [flrc_pkg::MAC_W-1:0]        own_mac,
	input  logic [flrc_pkg::MAC_W-1:0]        peer_mac,
	input  flrc_pkg::pend_t                   pend,
	output logic                              wr_en,
	output logic [$clog2(STORE_DEPTH)-1:0]    wr_off,
	output logic [7:0]                        wr_data,
	output flrc_pkg::frame_res_t              res
);
	localparam int OFF_W = $clog2(STORE_DEPTH);

	logic [flrc_pkg::POS_W-1:0] pos_q;
	logic [63:0]                hdr_q;
	logic [1:0]                 addr_ok_q;

	logic [63:0]                hdr_next;
	logic [1:0]                 addr_next;
	logic [2:0]                 own_k;
	logic [2:0]                 peer_k;
	logic [2:0]                 hdr_k;
	logic [flrc_pkg::POS_W-1:0] data_off;
	logic [15:0]                len;
	logic [7:0]                 func;
	logic [7:0]                 sub;
	logic [15:0]                cnt_len;
	logic [15:0]                cnt_got;
	logic [15:0]                cnt;
	logic                       hit;
	flrc_pkg::verdict_t         verdict;

	assign own_k    = 3'd5 - pos_q[2:0];
	assign peer_k   = 3'(4'd11 - pos_q[3:0]);
	assign hdr_k    = 3'(5'd23 - pos_q[4:0]);
	assign data_off = pos_q - flrc_pkg::POS_DATA_START;

	// address flags: bit 0 destination, bit 1 source
	always_comb begin
		addr_next = addr_ok_q;
		if (pos_q < flrc_pkg::POS_SRC_START) begin
			if (byte_in != own_mac[{own_k, 3'b000} +: 8]) begin
				addr_next[0] = 1'b0;
			end
		end else if (pos_q < 11'd12) begin
			if (byte_in != peer_mac[{peer_k, 3'b000} +: 8]) begin
				addr_next[1] = 1'b0;
			end
		end
	end

	always_comb begin
		hdr_next = hdr_q;
		if (pos_q >= flrc_pkg::POS_HDR_START && pos_q < flrc_pkg::POS_ECHO_END) begin
			hdr_next[{hdr_k, 3'b000} +: 8] = byte_in;
		end
	end

	assign wr_en   = step && pos_q >= flrc_pkg::POS_DATA_START
		&& data_off < flrc_pkg::POS_W'(STORE_DEPTH);
	assign wr_off  = OFF_W'(data_off);
	assign wr_data = byte_in;

	assign len  = hdr_next[63:48];
	assign func = hdr_next[47:40];
	assign sub  = hdr_next[39:32];
	assign hit  = (len == flrc_pkg::RESP_GET_LEN && func == flrc_pkg::RESP_GET_FUNC
		&& sub == flrc_pkg::RESP_GET_SUB)
		|| (len == flrc_pkg::RESP_SET_LEN && func == flrc_pkg::RESP_SET_FUNC
		&& sub == flrc_pkg::RESP_SET_SUB);

	// bytes of the frame at or past byte 20, plus one for the last byte itself
	assign cnt_len = len - 16'd2;
	assign cnt_got = 16'(pos_q) - 16'd19;

	always_comb begin
		cnt = cnt_len;
		if (cnt > cnt_got) begin
			cnt = cnt_got;
		end
		if (cnt > 16'(STORE_DEPTH)) begin
			cnt = 16'(STORE_DEPTH);
		end
	end

	always_comb begin
		if (pos_q < 11'd19) begin
			verdict = flrc_pkg::VERDICT_SHORT;
		end else if (addr_next != 2'b11) begin
			verdict = flrc_pkg::VERDICT_ADDRESS;
		end else if (pend.get ? (func != pend.func || sub != pend.sub)
			: (func != flrc_pkg::SET_FUNC || sub != flrc_pkg::SET_SUB)) begin
			verdict = flrc_pkg::VERDICT_FUNC;
		end else if (!hit) begin
			verdict = flrc_pkg::VERDICT_LENGTH;
		end else if (!pend.get && (pos_q < 11'd23 || hdr_next[31:16] != pend.seq
			|| hdr_next[15:8] != pend.func || hdr_next[7:0] != pend.sub)) begin
			verdict = flrc_pkg::VERDICT_ECHO;
		end else begin
			verdict = flrc_pkg::VERDICT_OK;
		end
	end

	assign res.fire    = step && last;
	assign res.verdict = verdict;
	assign res.accept  = verdict == flrc_pkg::VERDICT_OK;
	assign res.count   = cnt[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			hdr_q     <= '0;
			addr_ok_q <= 2'b11;
		end else if (step) begin
			if (last) begin
				pos_q     <= '0;
				hdr_q     <= '0;
				addr_ok_q <= 2'b11;
			end else begin
				if (pos_q != flrc_pkg::POS_MAX) begin
					pos_q <= pos_q + 11'd1;
				end
				hdr_q     <= hdr_next;
				addr_ok_q <= addr_next;
			end
		end
	end
endmodule

// ===== rtl/fpga_link_response_checker.sv =====
`timescale 1ns / 1ps
// top level of the link response checker: input register, request state, result register
// depends on flrc_pkg, flrc_if, flrc_frame and flrc_store
//
// The checker takes one item per clock while it is not held, and gives its result thus:
// the item is held in an input register, then one pass of shallow compares updates the
// request and frame state and loads the result register (store reads land in a registered
// memory output at the same edge). A record request and a read each give one result, a
// frame byte gives one only when it is marked last, and kind 3 gives none. While a
// result waits for its transfer the pipeline holds, so input ready follows output ready
// once both registers are full. Captured get data lives in a two-bank store of
// 2*STORE_DEPTH bytes; a frame writes the idle bank and an accepted get flips banks, so
// a rejected frame leaves the data visible before it intact. Store entries are not
// cleared at reset; only entries inside the captured count are ever read back.
module fpga_link_response_checker #(
	parameter int STORE_DEPTH = flrc_pkg::STORE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [0:0]                 wr_index,
	input  logic [flrc_pkg::MAC_W-1:0] wr_data,
	flrc_in_if.sink                    item,
	flrc_out_if.source                 result
);
	localparam int OFF_W = $clog2(STORE_DEPTH);

	// configuration
	logic [flrc_pkg::MAC_W-1:0] own_mac_q;
	logic [flrc_pkg::MAC_W-1:0] peer_mac_q;

	// input register
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] req_func_s1;
	logic [7:0] req_subfunc_s1;
	logic       req_is_get_s1;
	logic [7:0] frame_byte_s1;
	logic       frame_last_s1;
	logic [4:0] read_index_s1;

	// request and capture state
	flrc_pkg::pend_t pend_q;
	logic [15:0]     next_seq_q;
	logic            done_q;
	logic            bank_q;
	logic [5:0]      count_q;

	// result register
	logic               res_valid_q;
	flrc_pkg::verdict_t res_verdict_q;
	logic               res_done_q;
	logic [15:0]        res_seq_q;
	logic [5:0]         res_count_q;
	logic               res_read_ok_q;

	logic                 adv;
	logic                 go;
	logic                 is_req;
	logic                 is_byte;
	logic                 is_read;
	logic                 read_ok;
	logic                 get_accept;
	logic                 done_next;
	logic [5:0]           count_next;
	logic                 st_wr_en;
	logic [OFF_W-1:0]     st_wr_off;
	logic [7:0]           st_wr_data;
	logic [7:0]           st_rd_data;
	flrc_pkg::frame_res_t fres;

	// the pass moves forward whenever the result register is free or being taken
	assign adv        = !res_valid_q || result.ready;
	assign go         = valid_s1 && adv;
	assign item.ready = !valid_s1 || adv;

	assign is_req  = kind_s1 == flrc_pkg::KIND_REQ;
	assign is_byte = kind_s1 == flrc_pkg::KIND_BYTE;
	assign is_read = kind_s1 == flrc_pkg::KIND_READ;

	// a read answers zero outside the captured bytes
	assign read_ok = ({1'b0, read_index_s1} < count_q)
		&& ({4'b0000, read_index_s1} < 9'(STORE_DEPTH));

	assign get_accept = fres.fire && fres.accept && pend_q.get;

	always_comb begin
		done_next = done_q;
		if (is_req) begin
			done_next = 1'b0;
		end else if (fres.fire && fres.accept) begin
			done_next = 1'b1;
		end
	end

	assign count_next = get_accept ? fres.count : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q  <= '0;
			peer_mac_q <= '0;
		end else if (wr_en) begin
			if (wr_index == flrc_pkg::REG_OWN_MAC) begin
				own_mac_q <= wr_data;
			end
			if (wr_index == flrc_pkg::REG_PEER_MAC) begin
				peer_mac_q <= wr_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1        <= item.kind;
			req_func_s1    <= item.req_func;
			req_subfunc_s1 <= item.req_subfunc;
			req_is_get_s1  <= item.req_is_get;
			frame_byte_s1  <= item.frame_byte;
			frame_last_s1  <= item.frame_last;
			read_index_s1  <= item.read_index;
		end
	end

	// request state, bank and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			next_seq_q <= '0;
			done_q     <= 1'b0;
			bank_q     <= 1'b0;
			count_q    <= '0;
		end else if (go) begin
			if (is_req) begin
				pend_q.func <= req_func_s1;
				pend_q.sub  <= req_subfunc_s1;
				pend_q.get  <= req_is_get_s1;
				pend_q.seq  <= next_seq_q;
				next_seq_q  <= next_seq_q + 16'd1;
			end
			if (get_accept) begin
				bank_q <= ~bank_q;
			end
			done_q  <= done_next;
			count_q <= count_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= go && (is_req || is_read || fres.fire);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_verdict_q <= fres.fire ? fres.verdict : flrc_pkg::VERDICT_OK;
			res_done_q    <= done_next;
			res_seq_q     <= is_req ? next_seq_q : pend_q.seq;
			res_count_q   <= count_next;
			res_read_ok_q <= is_read && read_ok;
		end
	end

	flrc_frame #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (go && is_byte),
		.byte_in  (frame_byte_s1),
		.last     (frame_last_s1),
		.own_mac  (own_mac_q),
		.peer_mac (peer_mac_q),
		.pend     (pend_q),
		.wr_en    (st_wr_en),
		.wr_off   (st_wr_off),
		.wr_data  (st_wr_data),
		.res      (fres)
	);

	// frames fill the idle bank, reads come from the live one
	flrc_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_bank (~bank_q),
		.wr_off  (st_wr_off),
		.wr_data (st_wr_data),
		.rd_en   (go && is_read),
		.rd_bank (bank_q),
		.rd_off  (OFF_W'(read_index_s1)),
		.rd_data (st_rd_data)
	);

	assign result.valid           = res_valid_q;
	assign result.verdict         = res_verdict_q;
	assign result.done_flag       = res_done_q;
	assign result.issued_sequence = res_seq_q;
	assign result.data_count      = res_count_q;
	assign result.data_byte       = res_read_ok_q ? st_rd_data : 8'd0;
endmodule
